### hdl/plim_pkg.sv
// plim_pkg: widths, formats, reset values and register indexes of the peak limiter
// used by peak_limiter_core; depends on nothing
package plim_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int GAIN_FRAC   = SAMPLE_BITS - 1;
    localparam int MUL_W       = ((COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS) + 2;
    localparam int DIV_STEPS   = GAIN_FRAC;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_BITS-1:0] UNITY_GAIN = SAMPLE_BITS'(1) << GAIN_FRAC;
    localparam longint SNAP_FULL = ((longint'(1) << GAIN_FRAC) * 99999) / 100000;
    localparam logic [SAMPLE_BITS-1:0] SNAP_LEVEL = SNAP_FULL[SAMPLE_BITS-1:0];

    localparam int CFG_DATA_W = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd3;

    localparam logic                   RST_ENABLE    = 1'b1;
    localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD = UNITY_GAIN;
    localparam logic [COEF_BITS-1:0]   RST_ATTACK    = 24'd16092521;
    localparam logic [COEF_BITS-1:0]   RST_RELEASE   = 24'd16772848;

endpackage

### hdl/peak_limiter_core.sv
// peak_limiter_core: per-sample peak limiter with envelope follower and smoothed gain
// depends on plim_pkg (widths, constants, register indexes)
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_sample_in
// output    out        o_out_valid / i_out_stall   o_sample_out, o_gain_now
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// the 23-step restoring divide for the target gain is the longest part of one
// transaction, and one shared multiplier serves envelope decay, gain smoothing
// and output scaling in turn. the input reopens at the edge that loads the result.
// i_rst_n is synchronous, active low; config registers return to their defaults.
// a held output does not stop the next transaction until its result is ready.
module peak_limiter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [plim_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [plim_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic        [plim_pkg::SAMPLE_BITS-1:0] o_gain_now,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [plim_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [plim_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SB = plim_pkg::SAMPLE_BITS;
    localparam int CB = plim_pkg::COEF_BITS;
    localparam int MW = plim_pkg::MUL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV,
        S_DECAY,
        S_CMP,
        S_DIV,
        S_BLEND,
        S_BLEND_WB,
        S_OUT,
        S_OUT_WB,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic                              r_enable;
    logic        [SB-1:0]              r_threshold;
    logic        [CB-1:0]              r_attack;
    logic        [CB-1:0]              r_release;
    logic        [SB-1:0]              r_env;
    logic        [SB-1:0]              r_gain;
    logic signed [SB-1:0]              r_sample;
    logic        [SB-1:0]              r_target;
    logic        [SB-1:0]              r_rem;
    logic        [SB-2:0]              r_quot;
    logic        [plim_pkg::DIV_CNT_W-1:0] r_cnt;
    logic signed [2*MW-1:0]            r_prod;
    logic signed [SB-1:0]              r_res;
    logic                              r_out_valid;
    logic signed [SB-1:0]              r_out_sample;
    logic        [SB-1:0]              r_out_gain;

    logic signed [MW-1:0]   w_mul_a;
    logic signed [MW-1:0]   w_mul_b;
    logic        [SB-1:0]   w_mag;
    logic        [SB:0]     w_rem2;
    logic                   w_fits;
    logic        [CB-1:0]   w_coef;
    logic signed [2*MW-1:0] w_round;
    logic        [SB-1:0]   w_new_gain;
    logic                   w_accept;
    logic                   w_load;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_mag    = r_sample[SB-1] ? (~r_sample + SB'(1)) : r_sample;
    assign w_rem2   = {r_rem, 1'b0};
    assign w_fits   = w_rem2 >= {1'b0, r_env};
    assign w_coef   = (r_enable && (r_target < r_gain)) ? r_attack : r_release;
    assign w_round  = r_prod + ((2*MW)'(1) <<< (CB - 1));
    assign w_new_gain = w_round[CB+SB-1:CB] + r_target;

    // shared multiplier operand selection
    always_comb begin
        w_mul_a = {2'b00, r_release};
        w_mul_b = MW'($signed({1'b0, r_env}));
        case (r_state)
            S_BLEND: begin
                w_mul_a = MW'($signed({1'b0, w_coef}));
                w_mul_b = MW'($signed({1'b0, r_gain}) - $signed({1'b0, r_target}));
            end
            S_OUT: begin
                w_mul_a = MW'(r_sample);
                w_mul_b = MW'($signed({1'b0, r_gain}));
            end
            default: begin
                w_mul_a = MW'($signed({1'b0, r_release}));
                w_mul_b = MW'($signed({1'b0, r_env}));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= plim_pkg::RST_ENABLE;
            r_threshold <= plim_pkg::RST_THRESHOLD;
            r_attack    <= plim_pkg::RST_ATTACK;
            r_release   <= plim_pkg::RST_RELEASE;
            r_env       <= '0;
            r_gain      <= plim_pkg::UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    plim_pkg::CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                    plim_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[SB-1:0];
                    plim_pkg::CFG_ATTACK:    r_attack    <= i_cfg_data[CB-1:0];
                    plim_pkg::CFG_RELEASE:   r_release   <= i_cfg_data[CB-1:0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_sample_in;
                        r_target <= plim_pkg::UNITY_GAIN;
                        if (r_enable) begin
                            r_state <= S_ENV;
                        end else if (r_gain < plim_pkg::UNITY_GAIN) begin
                            r_state <= S_BLEND;
                        end else begin
                            r_res   <= i_sample_in;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ENV: begin
                    if (w_mag > r_env) begin
                        r_env   <= w_mag;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_DECAY;
                    end
                end
                S_DECAY: begin
                    r_env   <= r_prod[CB+SB-1:CB];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_rem  <= r_threshold;
                    r_quot <= '0;
                    r_cnt  <= '0;
                    if (r_env > r_threshold) begin
                        r_state <= S_DIV;
                    end else begin
                        r_target <= plim_pkg::UNITY_GAIN;
                        r_state  <= S_BLEND;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (w_fits) begin
                        r_rem <= SB'(w_rem2 - {1'b0, r_env});
                    end else begin
                        r_rem <= w_rem2[SB-1:0];
                    end
                    r_quot <= {r_quot[SB-3:0], w_fits};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == plim_pkg::DIV_CNT_W'(plim_pkg::DIV_STEPS - 1)) begin
                        r_target <= {1'b0, r_quot[SB-3:0], w_fits};
                        r_state  <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    r_state <= S_BLEND_WB;
                end
                S_BLEND_WB: begin
                    if (r_enable) begin
                        r_gain  <= w_new_gain;
                        r_state <= S_OUT;
                    end else begin
                        r_gain  <= (w_new_gain > plim_pkg::SNAP_LEVEL) ?
                                   plim_pkg::UNITY_GAIN : w_new_gain;
                        r_res   <= r_sample;
                        r_state <= S_DONE;
                    end
                end
                S_OUT: begin
                    r_state <= S_OUT_WB;
                end
                S_OUT_WB: begin
                    r_res   <= r_prod[plim_pkg::GAIN_FRAC+SB-1:plim_pkg::GAIN_FRAC];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_sample <= r_res;
                        r_out_gain   <= r_gain;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_gain_now   = r_out_gain;

`ifndef NO_ASSERTIONS
    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= plim_pkg::UNITY_GAIN)
        else $error("smoothed gain above unity");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_env))
        else $error("divide remainder not below envelope");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken while busy");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (o_gain_now == $past(r_gain))))
        else $error("result not presented after load");
`endif

endmodule
